// ===== hdl/sept_pkg.sv =====
// ============================================================================
// sept_pkg
// Shared types and constants of the sonar echo pulse timer: phase codes,
// configuration register indexes, reset values and the wait counter control.
// ============================================================================
package sept_pkg;

    // Configuration port
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERFLOW_LIMIT = 2'd2;

    localparam int unsigned TRIGGER_BITS = 16;
    localparam int unsigned GAP_BITS     = 24;
    localparam int unsigned WRAP_BITS    = 8;
    localparam int unsigned BYTE_BITS    = 8;

    localparam logic [TRIGGER_BITS-1:0] TRIGGER_LENGTH_RESET = 16'd200;
    localparam logic [GAP_BITS-1:0]     GAP_LENGTH_RESET     = 24'd200000;
    localparam logic [WRAP_BITS-1:0]    OVERFLOW_LIMIT_RESET = 8'd255;

    // Phase codes
    localparam int unsigned PHASE_BITS = 3;
    localparam logic [PHASE_BITS-1:0] PH_TRIGGER = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_RISE    = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_FALL    = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_SEND    = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_GAP     = 3'd4;

    // Frame layout: four marker bytes, low byte, high byte
    localparam int unsigned INDEX_BITS = 3;
    localparam logic [INDEX_BITS-1:0] IDX_LOW_BYTE  = 3'd4;
    localparam logic [INDEX_BITS-1:0] IDX_HIGH_BYTE = 3'd5;

    // Wait counter command
    typedef struct packed {
        logic clear;
        logic advance;
    } cnt_ctrl_t;

endpackage

// ===== hdl/sept_echo_if.sv =====
// ============================================================================
// sept_echo_if
// Input channel: one sampled echo level per transfer.
// ============================================================================
interface sept_echo_if;

    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);

endinterface

// ===== hdl/sept_result_if.sv =====
// ============================================================================
// sept_result_if
// Output channel: trigger drive and frame byte for one tick per transfer.
// ============================================================================
interface sept_result_if;

    logic       valid;
    logic       ready;
    logic       trigger_level;
    logic       byte_valid;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output trigger_level, output byte_valid,
                    output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input trigger_level, input byte_valid,
                    input frame_byte, input frame_last, output ready);

endinterface

// ===== hdl/sonar_echo_pulse_timer.sv =====
// ============================================================================
// sonar_echo_pulse_timer
// Ultrasonic ranging sequencer: trigger pulse, echo wait, echo width
// measurement and six-byte result frame, one echo sample per tick.
// ============================================================================
// Each transfer on the echo channel is one tick of the timer and yields one
// transfer on the result channel from the output register, one per clock
// cycle. The sequence repeats: the trigger line is driven high for
// trigger_length ticks, the block waits for the echo to rise, then counts how
// long it stays high. Both waits count ticks in a COUNTER_BITS-bit counter and
// add one to an 8-bit wrap count on each counter wrap; a wait is abandoned
// when the wrap count reaches overflow_limit (0 means 256 wraps). A falling
// echo captures the low byte of the tick counter; a timeout keeps the previous
// low byte. The frame 1,2,3,4,low,wraps then goes out on six consecutive ticks
// with byte_valid high and frame_last marking the sixth byte, followed by
// gap_length idle ticks. Lengths of 0 act as 1. The result sits in an output
// register, so the next sample is taken while a result waits to be taken;
// samples stall only when that register is full and not being taken.
// Configuration writes take effect on the next tick.
// ============================================================================
module sonar_echo_pulse_timer #(
    parameter int unsigned COUNTER_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    sept_echo_if.sink                           echo,
    sept_result_if.source                       result,
    input  logic                                cfg_write,
    input  logic [sept_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sept_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // Width that holds the tick counter and a full byte for the low capture
    localparam int unsigned LOW_SRC_BITS = (COUNTER_BITS > 8) ? COUNTER_BITS : 8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [sept_pkg::TRIGGER_BITS-1:0] trigger_length_reg;
    logic [sept_pkg::GAP_BITS-1:0]     gap_length_reg;
    logic [sept_pkg::WRAP_BITS-1:0]    overflow_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_length_reg <= sept_pkg::TRIGGER_LENGTH_RESET;
            gap_length_reg     <= sept_pkg::GAP_LENGTH_RESET;
            overflow_limit_reg <= sept_pkg::OVERFLOW_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sept_pkg::CFG_TRIGGER_LENGTH:
                    trigger_length_reg <= cfg_data[sept_pkg::TRIGGER_BITS-1:0];
                sept_pkg::CFG_GAP_LENGTH:
                    gap_length_reg <= cfg_data[sept_pkg::GAP_BITS-1:0];
                sept_pkg::CFG_OVERFLOW_LIMIT:
                    overflow_limit_reg <= cfg_data[sept_pkg::WRAP_BITS-1:0];
                default:
                    ; // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: take a sample whenever the output register can be loaded
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic out_valid_next;
    logic in_fire;

    assign echo.ready = !out_valid_reg || result.ready;
    assign in_fire    = echo.valid && echo.ready;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [sept_pkg::PHASE_BITS-1:0] phase_reg;
    logic [sept_pkg::PHASE_BITS-1:0] phase_next;
    logic [sept_pkg::GAP_BITS-1:0]   phase_timer_reg;
    logic [sept_pkg::GAP_BITS-1:0]   phase_timer_next;
    logic [sept_pkg::BYTE_BITS-1:0]  captured_low_reg;
    logic [sept_pkg::BYTE_BITS-1:0]  captured_low_next;
    logic [sept_pkg::INDEX_BITS-1:0] byte_index_reg;
    logic [sept_pkg::INDEX_BITS-1:0] byte_index_next;

    // Wait counter
    sept_pkg::cnt_ctrl_t               cnt_ctrl;
    logic [COUNTER_BITS-1:0]           tick_count;
    logic [sept_pkg::WRAP_BITS-1:0]    wrap_count;
    logic                              timeout;
    logic [LOW_SRC_BITS-1:0]           tick_wide;

    sept_wait_counter #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_wait_counter (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (cnt_ctrl),
        .overflow_limit (overflow_limit_reg),
        .tick_count     (tick_count),
        .wrap_count     (wrap_count),
        .timeout        (timeout)
    );

    assign tick_wide = LOW_SRC_BITS'(tick_count);

    // Phase lengths, with zero treated as one
    logic [sept_pkg::GAP_BITS-1:0] timer_inc;
    logic [sept_pkg::GAP_BITS-1:0] trigger_len;
    logic [sept_pkg::GAP_BITS-1:0] gap_len;

    assign timer_inc   = phase_timer_reg + sept_pkg::GAP_BITS'(1);
    assign trigger_len = (trigger_length_reg == '0) ? sept_pkg::GAP_BITS'(1)
                                                    : sept_pkg::GAP_BITS'(trigger_length_reg);
    assign gap_len     = (gap_length_reg == '0) ? sept_pkg::GAP_BITS'(1) : gap_length_reg;

    // Result of this tick
    logic                           trig_next;
    logic                           bvalid_next;
    logic [sept_pkg::BYTE_BITS-1:0] fbyte_next;
    logic                           flast_next;

    always_comb
    begin
        phase_next        = phase_reg;
        phase_timer_next  = phase_timer_reg;
        captured_low_next = captured_low_reg;
        byte_index_next   = byte_index_reg;
        cnt_ctrl          = '0;
        trig_next         = 1'b0;
        bvalid_next       = 1'b0;
        fbyte_next        = '0;
        flast_next        = 1'b0;

        unique case (phase_reg)
            sept_pkg::PH_RISE:
            begin
                // Leave on rising echo or on timeout, fresh counters either way
                if (echo.echo_level || timeout)
                begin
                    cnt_ctrl.clear = 1'b1;
                    phase_next     = sept_pkg::PH_FALL;
                end
                else
                begin
                    cnt_ctrl.advance = 1'b1;
                end
            end
            sept_pkg::PH_FALL:
            begin
                if (!echo.echo_level)
                begin
                    // Falling edge: capture the low byte, hold the counters
                    captured_low_next = tick_wide[sept_pkg::BYTE_BITS-1:0];
                    byte_index_next   = '0;
                    phase_next        = sept_pkg::PH_SEND;
                end
                else
                begin
                    cnt_ctrl.advance = 1'b1;
                    if (timeout)
                    begin
                        byte_index_next = '0;
                        phase_next      = sept_pkg::PH_SEND;
                    end
                end
            end
            sept_pkg::PH_SEND:
            begin
                bvalid_next = 1'b1;
                if (byte_index_reg < sept_pkg::IDX_LOW_BYTE)
                begin
                    fbyte_next = sept_pkg::BYTE_BITS'(byte_index_reg)
                               + sept_pkg::BYTE_BITS'(1);
                end
                else if (byte_index_reg == sept_pkg::IDX_LOW_BYTE)
                begin
                    fbyte_next = captured_low_reg;
                end
                else
                begin
                    fbyte_next = wrap_count;
                end

                if (byte_index_reg >= sept_pkg::IDX_HIGH_BYTE)
                begin
                    flast_next       = 1'b1;
                    byte_index_next  = '0;
                    phase_timer_next = '0;
                    phase_next       = sept_pkg::PH_GAP;
                end
                else
                begin
                    byte_index_next = byte_index_reg + sept_pkg::INDEX_BITS'(1);
                end
            end
            sept_pkg::PH_GAP:
            begin
                phase_timer_next = timer_inc;
                if (timer_inc >= gap_len)
                begin
                    phase_timer_next = '0;
                    phase_next       = sept_pkg::PH_TRIGGER;
                end
            end
            default:
            begin
                // Trigger phase; unused codes behave the same way
                trig_next        = 1'b1;
                phase_timer_next = timer_inc;
                if (timer_inc >= trigger_len)
                begin
                    phase_timer_next = '0;
                    cnt_ctrl.clear   = 1'b1;
                    phase_next       = sept_pkg::PH_RISE;
                end
            end
        endcase

        // Nothing moves without a sample
        if (!in_fire)
        begin
            cnt_ctrl = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= sept_pkg::PH_TRIGGER;
            phase_timer_reg  <= '0;
            captured_low_reg <= '0;
            byte_index_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            phase_timer_reg  <= phase_timer_next;
            captured_low_reg <= captured_low_next;
            byte_index_reg   <= byte_index_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                           trigger_level_reg;
    logic                           byte_valid_reg;
    logic [sept_pkg::BYTE_BITS-1:0] frame_byte_reg;
    logic                           frame_last_reg;

    assign out_valid_next = in_fire || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            trigger_level_reg <= trig_next;
            byte_valid_reg    <= bvalid_next;
            frame_byte_reg    <= fbyte_next;
            frame_last_reg    <= flast_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.trigger_level = trigger_level_reg;
    assign result.byte_valid    = byte_valid_reg;
    assign result.frame_byte    = frame_byte_reg;
    assign result.frame_last    = frame_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The frame index never runs past the high byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sept_pkg::PH_SEND) |-> (byte_index_reg <= sept_pkg::IDX_HIGH_BYTE))
    else $error("frame byte index out of range");

    // The last mark only comes with a frame byte, and never during a trigger
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frame_last) |-> (result.byte_valid && !result.trigger_level))
    else $error("frame_last without a frame byte");

    // A frame ends by entering the gap phase with a cleared timer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && flast_next) |=> (phase_reg == sept_pkg::PH_GAP && phase_timer_reg == '0))
    else $error("frame end did not enter the gap");

endmodule

// ===== hdl/sept_wait_counter.sv =====
// ============================================================================
// sept_wait_counter
// Tick counter with wrap count and timeout detect for the echo waits.
// ============================================================================
module sept_wait_counter #(
    parameter int unsigned COUNTER_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sept_pkg::cnt_ctrl_t              ctrl,
    input  logic [sept_pkg::WRAP_BITS-1:0]   overflow_limit,
    output logic [COUNTER_BITS-1:0]          tick_count,
    output logic [sept_pkg::WRAP_BITS-1:0]   wrap_count,
    output logic                             timeout
);

    logic [COUNTER_BITS-1:0]        tick_reg;
    logic [COUNTER_BITS-1:0]        tick_next;
    logic [sept_pkg::WRAP_BITS-1:0] wrap_reg;
    logic [sept_pkg::WRAP_BITS-1:0] wrap_next;
    logic [sept_pkg::WRAP_BITS-1:0] wrap_inc;
    logic                           tick_wraps;

    assign tick_wraps = (tick_reg == {COUNTER_BITS{1'b1}});
    assign wrap_inc   = wrap_reg + sept_pkg::WRAP_BITS'(1);
    // The wait gives up on the tick whose wrap brings the count to the limit
    assign timeout    = tick_wraps && (wrap_inc == overflow_limit);

    always_comb
    begin
        tick_next = tick_reg;
        wrap_next = wrap_reg;
        priority if (ctrl.clear)
        begin
            tick_next = '0;
            wrap_next = '0;
        end
        else if (ctrl.advance)
        begin
            tick_next = tick_reg + COUNTER_BITS'(1);
            if (tick_wraps)
            begin
                wrap_next = wrap_inc;
            end
        end
        else
        begin
            // Hold both counts
            tick_next = tick_reg;
            wrap_next = wrap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            wrap_reg <= '0;
        end
        else
        begin
            tick_reg <= tick_next;
            wrap_reg <= wrap_next;
        end
    end

    assign tick_count = tick_reg;
    assign wrap_count = wrap_reg;

endmodule

// ===== dv/sonar_echo_pulse_timer_test.sv =====
// ============================================================================
// sonar_echo_pulse_timer_test
// Self-checking bench for the sonar echo pulse timer. Echo samples go in on
// the echo channel, and each one is tracked through a cycle-exact copy of the
// ranging sequence: trigger, rise wait, fall wait, six-byte frame, gap. Every
// result transfer is compared field by field with the oldest predicted tick.
// ============================================================================
module sonar_echo_pulse_timer_test;

    localparam int unsigned COUNTER_BITS    = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned REPORT_LIMIT    = 10;

    // One result transfer: trigger drive and frame byte for one tick
    typedef struct packed {
        logic                           trigger_level;
        logic                           byte_valid;
        logic [sept_pkg::BYTE_BITS-1:0] frame_byte;
        logic                           frame_last;
    } tick_out_t;

    // ------------------------------------------------------------------------
    // Ranging cycle tracker: mirrors the sequencer state and registers, and
    // queues the tick output that every accepted echo sample must produce.
    // ------------------------------------------------------------------------
    class ranging_cycle_tracker;
        logic [sept_pkg::TRIGGER_BITS-1:0] trig_len;
        logic [sept_pkg::GAP_BITS-1:0]     gap_len;
        logic [sept_pkg::WRAP_BITS-1:0]    wrap_limit;

        logic [sept_pkg::PHASE_BITS-1:0]   ph;
        logic [COUNTER_BITS-1:0]           ticks;
        logic [sept_pkg::WRAP_BITS-1:0]    wraps;
        logic [sept_pkg::BYTE_BITS-1:0]    low_byte;
        logic [sept_pkg::GAP_BITS-1:0]     timer;
        logic [sept_pkg::INDEX_BITS-1:0]   frame_idx;

        tick_out_t due_ticks[$];
        int        samples;
        int        ticks_checked;
        int        frames;
        int        rise_timeouts;
        int        fall_timeouts;
        int        mismatches;

        function new();
            trig_len      = sept_pkg::TRIGGER_LENGTH_RESET;
            gap_len       = sept_pkg::GAP_LENGTH_RESET;
            wrap_limit    = sept_pkg::OVERFLOW_LIMIT_RESET;
            ph            = sept_pkg::PH_TRIGGER;
            ticks         = '0;
            wraps         = '0;
            low_byte      = '0;
            timer         = '0;
            frame_idx     = '0;
            samples       = 0;
            ticks_checked = 0;
            frames        = 0;
            rise_timeouts = 0;
            fall_timeouts = 0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [sept_pkg::CFG_INDEX_BITS-1:0] idx,
                              logic [sept_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                sept_pkg::CFG_TRIGGER_LENGTH: trig_len   = data[sept_pkg::TRIGGER_BITS-1:0];
                sept_pkg::CFG_GAP_LENGTH:     gap_len    = data[sept_pkg::GAP_BITS-1:0];
                sept_pkg::CFG_OVERFLOW_LIMIT: wrap_limit = data[sept_pkg::WRAP_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Advance the wait counter; true when the wrap count hits the limit
        function bit wait_expired();
            ticks = ticks + 1'b1;
            if (ticks == '0)
            begin
                wraps = wraps + 1'b1;
                return wraps == wrap_limit;
            end
            return 1'b0;
        endfunction

        function void take_sample(logic echo_lvl);
            tick_out_t                     o;
            logic [sept_pkg::GAP_BITS-1:0] span;
            o = '0;
            case (ph)
                sept_pkg::PH_RISE:
                begin
                    if (echo_lvl || wait_expired())
                    begin
                        if (!echo_lvl)
                            rise_timeouts++;
                        ticks = '0;
                        wraps = '0;
                        ph    = sept_pkg::PH_FALL;
                    end
                end
                sept_pkg::PH_FALL:
                begin
                    if (!echo_lvl)
                    begin
                        low_byte  = 8'(ticks);
                        frame_idx = '0;
                        ph        = sept_pkg::PH_SEND;
                    end
                    else if (wait_expired())
                    begin
                        fall_timeouts++;
                        frame_idx = '0;
                        ph        = sept_pkg::PH_SEND;
                    end
                end
                sept_pkg::PH_SEND:
                begin
                    o.byte_valid = 1'b1;
                    if (frame_idx < sept_pkg::IDX_LOW_BYTE)
                        o.frame_byte = 8'(frame_idx) + 8'd1;
                    else if (frame_idx == sept_pkg::IDX_LOW_BYTE)
                        o.frame_byte = low_byte;
                    else
                        o.frame_byte = wraps;
                    if (frame_idx >= sept_pkg::IDX_HIGH_BYTE)
                    begin
                        o.frame_last = 1'b1;
                        frames++;
                        frame_idx = '0;
                        timer     = '0;
                        ph        = sept_pkg::PH_GAP;
                    end
                    else
                        frame_idx = frame_idx + 1'b1;
                end
                sept_pkg::PH_GAP:
                begin
                    span  = (gap_len == '0) ? sept_pkg::GAP_BITS'(1) : gap_len;
                    timer = timer + 1'b1;
                    if (timer >= span)
                    begin
                        timer = '0;
                        ph    = sept_pkg::PH_TRIGGER;
                    end
                end
                default:
                begin
                    o.trigger_level = 1'b1;
                    span  = (trig_len == '0) ? sept_pkg::GAP_BITS'(1)
                                             : sept_pkg::GAP_BITS'(trig_len);
                    timer = timer + 1'b1;
                    if (timer >= span)
                    begin
                        timer = '0;
                        ticks = '0;
                        wraps = '0;
                        ph    = sept_pkg::PH_RISE;
                    end
                end
            endcase
            due_ticks.push_back(o);
            samples++;
        endfunction

        function void check_tick(tick_out_t got);
            tick_out_t want;
            if (due_ticks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"ERROR: result transfer with no tick pending: ",
                              "trig=%0b valid=%0b byte=%0d last=%0b"},
                             got.trigger_level, got.byte_valid, got.frame_byte,
                             got.frame_last);
                return;
            end
            want = due_ticks.pop_front();
            ticks_checked++;
            if (got.trigger_level !== want.trigger_level ||
                got.byte_valid !== want.byte_valid ||
                got.frame_byte !== want.frame_byte || got.frame_last !== want.frame_last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"ERROR: tick %0d: expected trig=%0b valid=%0b byte=%0d ",
                              "last=%0b, got trig=%0b valid=%0b byte=%0d last=%0b"},
                             ticks_checked, want.trigger_level, want.byte_valid,
                             want.frame_byte, want.frame_last, got.trigger_level,
                             got.byte_valid, got.frame_byte, got.frame_last);
            end
        endfunction

        function int pending();
            return due_ticks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic                                cfg_write;
    logic [sept_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [sept_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sept_echo_if   echo_ch();
    sept_result_if result_ch();

    sonar_echo_pulse_timer #(
        .COUNTER_BITS(COUNTER_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .echo     (echo_ch),
        .result   (result_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    ranging_cycle_tracker ranging = new();

    // Idle percentages of both sides, shaping knobs of the echo pattern
    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 70;
    int unsigned long_pct      = 15;    // share of waits drawn long, most of them long enough to wrap
    int unsigned noise_pct     = 8;     // share of samples replaced by a random level
    int          rise_override = -1;    // forced rise delay when not negative
    int unsigned hold_requests = 0;     // bumped to ask the receiver for a hold-off
    int unsigned cycle_count   = 0;
    int unsigned cfg_writes    = 0;

    // Echo pattern state: position inside the current wait and its plan
    logic [sept_pkg::PHASE_BITS-1:0] seen_ph    = sept_pkg::PH_TRIGGER;
    int                              ph_samples = 0;
    int                              rise_delay = 0;
    int                              echo_width = 0;

    // ------------------------------------------------------------------------
    // Watchdog: end the run if it hangs
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d ticks still pending", cycle_count,
                 ranging.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: drive ready at the falling edge; serve hold-off requests by
    // holding ready low for a long stretch while the sender keeps going.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned served;
        int unsigned stall_left;
        served          = 0;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (served != hold_requests)
            begin
                served     = hold_requests;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result transfer at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            ranging.check_tick('{result_ch.trigger_level, result_ch.byte_valid,
                                 result_ch.frame_byte, result_ch.frame_last});
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------------

    // Draw a wait length: mostly short, sometimes long enough to wrap
    function int draw_wait_length();
        if ($urandom_range(99) < long_pct)
            return $urandom_range(700, 200);
        return $urandom_range(15);
    endfunction

    // Pick the next echo level from the phase the block is predicted to be
    // in: low through the rise delay, high for the planned width, low else.
    function logic next_echo();
        logic lvl;
        if (ranging.ph != seen_ph)
        begin
            seen_ph    = ranging.ph;
            ph_samples = 0;
            if (seen_ph == sept_pkg::PH_RISE)
                rise_delay = (rise_override >= 0) ? rise_override : draw_wait_length();
            if (seen_ph == sept_pkg::PH_FALL)
                echo_width = draw_wait_length();
        end
        case (seen_ph)
            sept_pkg::PH_RISE: lvl = (ph_samples >= rise_delay);
            sept_pkg::PH_FALL: lvl = (ph_samples < echo_width);
            default:           lvl = 1'b0;
        endcase
        ph_samples++;
        if ($urandom_range(99) < noise_pct)
            lvl = 1'($urandom_range(1));
        return lvl;
    endfunction

    // Offer one sample, idling at random first; leave valid high afterwards
    task automatic send_echo(logic lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            echo_ch.valid <= 1'b0;
            @(negedge clk);
        end
        echo_ch.valid      <= 1'b1;
        echo_ch.echo_level <= lvl;
        @(posedge clk);
        while (!echo_ch.ready)
            @(posedge clk);
        ranging.take_sample(lvl);
        @(negedge clk);
    endtask

    task automatic run_items(int n);
        repeat (n)
            send_echo(next_echo());
    endtask

    task automatic run_until_phase(logic [sept_pkg::PHASE_BITS-1:0] target);
        while (ranging.ph != target)
            send_echo(next_echo());
    endtask

    // Drop valid and hold until every predicted tick has come back
    task automatic drain();
        echo_ch.valid <= 1'b0;
        @(negedge clk);
        while (ranging.pending() != 0)
            @(negedge clk);
        repeat (3)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [sept_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [sept_pkg::CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        ranging.set_reg(idx, data);
        cfg_writes++;
        @(negedge clk);
    endtask

    // Write all three registers back to back; only call with the block idle
    task automatic program_regs(int unsigned trig, int unsigned gap, int unsigned limit);
        write_reg(sept_pkg::CFG_TRIGGER_LENGTH, sept_pkg::CFG_DATA_BITS'(trig));
        write_reg(sept_pkg::CFG_GAP_LENGTH, sept_pkg::CFG_DATA_BITS'(gap));
        write_reg(sept_pkg::CFG_OVERFLOW_LIMIT, sept_pkg::CFG_DATA_BITS'(limit));
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        logic at_reset[6];
        logic first_run[19];
        int   leftover;

        at_reset  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        first_run = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                      1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                      1'b0};

        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        echo_ch.valid      = 1'b0;
        echo_ch.echo_level = 1'b0;
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: a long trigger, so echo levels of both kinds are
        // ignored and only the trigger drive shows.
        foreach (at_reset[i])
            send_echo(at_reset[i]);
        drain();

        // Zero lengths act as one and a limit of one: leave the trigger at
        // once, rise and fall on the first samples (low byte zero), ignore a
        // high echo during the frame, gap and trigger, then a short pulse.
        program_regs(0, 0, 1);
        foreach (first_run[i])
            send_echo(first_run[i]);
        drain();

        // Sender idles a little, receiver a lot; one long receiver hold-off
        // in the middle so the block backs up and stalls the echo side.
        send_idle_pct = 27;
        recv_idle_pct = 70;
        program_regs($urandom_range(8, 1), $urandom_range(8, 1), 1);
        run_items(90);
        hold_requests++;
        run_items(90);
        run_until_phase(sept_pkg::PH_TRIGGER);
        drain();

        // Longest trigger pulse for a stretch
        program_regs(16'hFFFF, 3, 2);
        run_items(40);
        drain();

        // Roles swapped; the sender pauses once until all ticks are back
        send_idle_pct = 70;
        recv_idle_pct = 27;
        program_regs($urandom_range(20, 1), $urandom_range(20, 1), 2);
        run_items(110);
        drain();
        run_items(110);
        run_until_phase(sept_pkg::PH_GAP);
        drain();

        // Longest gap for a stretch
        program_regs(3, 24'hFFFFFF, 3);
        run_items(40);
        drain();

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs($urandom_range(20, 1), $urandom_range(20, 1), $urandom_range(3, 1));
        run_items(120);
        drain();
        program_regs(5, 4, 255);
        run_items(80);
        run_until_phase(sept_pkg::PH_TRIGGER);
        drain();

        // Zero overflow limit: the wrap count never matches on its first
        // wraps, so a silent echo runs past a full counter wrap where a limit
        // of one would already have ended the wait.
        program_regs(1, 1, 0);
        noise_pct     = 0;
        long_pct      = 0;
        rise_override = 300;
        run_until_phase(sept_pkg::PH_SEND);
        run_items(10);
        drain();

        leftover = ranging.pending();
        if (leftover != 0)
            $display("ERROR: %0d predicted ticks never came back", leftover);
        $display("Covered %0d echo samples over %0d register writes: %0d frames",
                 ranging.samples, cfg_writes, ranging.frames);
        $display("Saw %0d rise and %0d fall timeouts; checked %0d transfers, %0d mismatches",
                 ranging.rise_timeouts, ranging.fall_timeouts, ranging.ticks_checked,
                 ranging.mismatches);
        if (ranging.mismatches == 0 && leftover == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
